// ===== hw/rtl/tcphr_pkg.sv =====
// ----------------------------------------------------------------------------
// tcphr_pkg
// shared types and constants for the tcp header timestamp/sequence rewriter
// ----------------------------------------------------------------------------
package tcphr_pkg;

  // header layout
  localparam logic [5:0] BaseLen = 6'd20;
  localparam logic [5:0] SeqPos  = 6'd4;
  localparam logic [5:0] SeqEnd  = 6'd8;
  localparam logic [5:0] DoffPos = 6'd12;
  localparam logic [5:0] PosMax  = 6'd63;

  // option kinds and lengths
  localparam logic [7:0] OptEnd   = 8'd0;
  localparam logic [7:0] OptNop   = 8'd1;
  localparam logic [7:0] OptTs    = 8'd8;
  localparam logic [7:0] OptTsLen = 8'd10;
  localparam logic [7:0] OptMinLen = 8'd2;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NO_OPTS    = 2'd1,
    ST_MALFORMED  = 2'd2,
    ST_BAD_TS_LEN = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_TS_OFFSET  = 2'd0,
    CFG_TS_ENABLE  = 2'd1,
    CFG_SEQ_OFFSET = 2'd2,
    CFG_SEQ_ENABLE = 2'd3
  } cfg_idx_t;

  typedef enum logic [6:0] {
    PH_KIND      = 7'b0000001,
    PH_LEN_OTHER = 7'b0000010,
    PH_LEN_TS    = 7'b0000100,
    PH_SKIP      = 7'b0001000,
    PH_TSVAL     = 7'b0010000,
    PH_TSECR     = 7'b0100000,
    PH_DONE      = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [31:0] ts_offset;
    logic        ts_enable;
    logic [31:0] seq_offset;
    logic        seq_enable;
  } cfg_t;

  // one group of output bytes, left aligned, msb first on the wire
  typedef struct packed {
    logic [31:0] data;
    logic [1:0]  nbytes_m1;
    logic        last;
    logic [1:0]  status;
  } row_t;

endpackage

// ===== hw/rtl/tcphr_if.sv =====
// ----------------------------------------------------------------------------
// tcphr_if
// valid/ready channels for header bytes in and rewritten bytes out
// ----------------------------------------------------------------------------
interface tcphr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hdr_byte;
  logic       last_in;

  modport source (output valid, output hdr_byte, output last_in, input ready);
  modport sink   (input valid, input hdr_byte, input last_in, output ready);
endinterface

interface tcphr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;
  logic [1:0] status;

  modport source (output valid, output out_byte, output last_out, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input last_out, input status,
                  output ready);
endinterface

// ===== hw/rtl/tcphr_parse.sv =====
// ----------------------------------------------------------------------------
// tcphr_parse
// per-byte header tracking, option walk, word hold and offset rewrite
// ----------------------------------------------------------------------------
module tcphr_parse
  import tcphr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       take,
  input  logic [7:0] hdr_byte,
  input  logic       last_in,
  output logic       push,
  output row_t       row
);

  logic [5:0]  pos, pos_next;
  logic [5:0]  hlen, hlen_next;
  phase_t      phase, phase_next;
  logic [7:0]  skip, skip_next;
  logic [31:0] hold, hold_next;
  logic [1:0]  wcnt, wcnt_next;
  logic [1:0]  rcode, rcode_next;

  logic        opts, in_area, walk, held, word_done, row_vld;
  logic [5:0]  remaining;
  logic [31:0] hold_shift, word_sum;
  logic [1:0]  wcnt_inc;
  logic [1:0]  status;
  row_t        row_c;

  always_comb begin
    hlen_next  = (pos == DoffPos) ? {hdr_byte[7:4], 2'b00} : hlen;
    opts       = hlen_next > BaseLen;
    in_area    = pos >= BaseLen;
    walk       = opts && in_area && (pos < hlen_next) && (phase != PH_DONE);
    remaining  = hlen_next - pos;
    held       = (wcnt != 2'd0) || ((pos == SeqPos) && cfg.seq_enable) ||
                 (walk && ((phase == PH_TSVAL) || (phase == PH_TSECR)));
    hold_shift = {hold[23:0], hdr_byte};
    wcnt_inc   = wcnt + 2'd1;
    word_done  = (wcnt == 2'd3);

    if (pos < SeqEnd) begin
      word_sum = cfg.seq_enable ? hold_shift + cfg.seq_offset : hold_shift;
    end else begin
      word_sum = cfg.ts_enable ? hold_shift + cfg.ts_offset : hold_shift;
    end

    pos_next   = pos;
    phase_next = phase;
    skip_next  = skip;
    hold_next  = hold;
    wcnt_next  = wcnt;
    rcode_next = rcode;
    row_vld    = 1'b0;
    row_c      = '0;
    status     = ST_OK;

    if (held) begin
      if (word_done) begin
        row_vld         = 1'b1;
        row_c.data      = word_sum;
        row_c.nbytes_m1 = 2'd3;
        hold_next       = '0;
        wcnt_next       = '0;
        if (pos >= SeqEnd) begin
          if (phase == PH_TSVAL) begin
            phase_next = PH_TSECR;
          end else begin
            phase_next = PH_DONE;
            rcode_next = ST_OK;
          end
        end
      end else begin
        hold_next = hold_shift;
        wcnt_next = wcnt_inc;
      end
    end else begin
      row_vld         = 1'b1;
      row_c.data      = {hdr_byte, 24'd0};
      row_c.nbytes_m1 = 2'd0;
      if (walk) begin
        case (phase)
          PH_KIND: begin
            if (hdr_byte == OptEnd) begin
              phase_next = PH_DONE;
              rcode_next = ST_OK;
            end else if (hdr_byte == OptNop) begin
              phase_next = PH_KIND;
            end else if (remaining < 6'd2) begin
              phase_next = PH_DONE;
              rcode_next = ST_MALFORMED;
            end else begin
              phase_next = (hdr_byte == OptTs) ? PH_LEN_TS : PH_LEN_OTHER;
            end
          end
          PH_LEN_OTHER: begin
            if ((hdr_byte < OptMinLen) || (hdr_byte > ({2'b00, remaining} + 8'd1))) begin
              phase_next = PH_DONE;
              rcode_next = ST_MALFORMED;
            end else if (hdr_byte == OptMinLen) begin
              phase_next = PH_KIND;
            end else begin
              skip_next  = hdr_byte - OptMinLen;
              phase_next = PH_SKIP;
            end
          end
          PH_LEN_TS: begin
            if (hdr_byte != OptTsLen) begin
              phase_next = PH_DONE;
              rcode_next = ST_BAD_TS_LEN;
            end else if (({2'b00, remaining} + 8'd1) < OptTsLen) begin
              phase_next = PH_DONE;
              rcode_next = ST_MALFORMED;
            end else begin
              phase_next = PH_TSVAL;
              hold_next  = '0;
              wcnt_next  = '0;
            end
          end
          PH_SKIP: begin
            skip_next = skip - 8'd1;
            if (skip_next == 8'd0) begin
              phase_next = PH_KIND;
            end
          end
          default: begin
            phase_next = phase;
          end
        endcase
      end
    end

    // option area ends with this byte
    if (opts && in_area && (({1'b0, pos} + 7'd1) == {1'b0, hlen_next}) &&
        (phase_next != PH_DONE)) begin
      rcode_next = (phase_next == PH_KIND) ? ST_OK : ST_MALFORMED;
      phase_next = PH_DONE;
    end

    if (last_in) begin
      if (!cfg.ts_enable) begin
        status = ST_OK;
      end else if (!opts) begin
        status = ST_NO_OPTS;
      end else if (phase_next == PH_DONE) begin
        status = rcode_next;
      end else begin
        status = ST_MALFORMED;
      end
      // partial word goes out unmodified
      if (held && !word_done) begin
        row_vld         = 1'b1;
        row_c.nbytes_m1 = wcnt_inc - 2'd1;
        case (wcnt_inc)
          2'd1:    row_c.data = {hold_shift[7:0], 24'd0};
          2'd2:    row_c.data = {hold_shift[15:0], 16'd0};
          2'd3:    row_c.data = {hold_shift[23:0], 8'd0};
          default: row_c.data = hold_shift;
        endcase
      end
      row_c.last   = 1'b1;
      row_c.status = status;
      pos_next     = '0;
      hlen_next    = '0;
      phase_next   = PH_KIND;
      skip_next    = '0;
      hold_next    = '0;
      wcnt_next    = '0;
      rcode_next   = ST_OK;
    end else if (pos != PosMax) begin
      pos_next = pos + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos   <= '0;
      hlen  <= '0;
      phase <= PH_KIND;
      skip  <= '0;
      hold  <= '0;
      wcnt  <= '0;
      rcode <= ST_OK;
    end else if (take) begin
      pos   <= pos_next;
      hlen  <= hlen_next;
      phase <= phase_next;
      skip  <= skip_next;
      hold  <= hold_next;
      wcnt  <= wcnt_next;
      rcode <= rcode_next;
    end
  end

  assign push = take && row_vld;
  assign row  = row_c;

endmodule

// ===== hw/rtl/tcphr_outq.sv =====
// ----------------------------------------------------------------------------
// tcphr_outq
// queue of output byte groups, drained one byte per transfer
// ----------------------------------------------------------------------------
module tcphr_outq
  import tcphr_pkg::*;
#(
  parameter int QDepth = 8
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  row_t row,
  output logic space,
  tcphr_out_if.source out_ch
);

  localparam int AW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CW = $clog2(QDepth + 1);
  localparam logic [AW-1:0] LastIdx = AW'(QDepth - 1);
  localparam logic [CW-1:0] Full    = CW'(QDepth);

  row_t          rows [QDepth];
  logic [AW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic [1:0]    sel;
  row_t          head;
  logic          byte_xfer, row_pop, row_end;

  assign head      = rows[rd_ptr];
  assign row_end   = (sel == head.nbytes_m1);
  assign byte_xfer = out_ch.valid && out_ch.ready;
  assign row_pop   = byte_xfer && row_end;
  assign space     = (count != Full);

  always_comb begin
    case (sel)
      2'd0:    out_ch.out_byte = head.data[31:24];
      2'd1:    out_ch.out_byte = head.data[23:16];
      2'd2:    out_ch.out_byte = head.data[15:8];
      default: out_ch.out_byte = head.data[7:0];
    endcase
  end

  assign out_ch.valid    = (count != '0);
  assign out_ch.last_out = head.last && row_end;
  assign out_ch.status   = out_ch.last_out ? head.status : ST_OK;

  always_ff @(posedge clk) begin
    if (push) begin
      rows[wr_ptr] <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      sel    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LastIdx) ? '0 : wr_ptr + AW'(1);
      end
      if (row_pop) begin
        rd_ptr <= (rd_ptr == LastIdx) ? '0 : rd_ptr + AW'(1);
        sel    <= '0;
      end else if (byte_xfer) begin
        sel <= sel + 2'd1;
      end
      case ({push, row_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (count != Full || row_pop))
    else $error("row pushed into a full queue");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= Full)
    else $error("queue count beyond depth");

  a_sel_in_row: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (sel <= head.nbytes_m1))
    else $error("byte select past end of row");

  a_sel_idle: assert property (@(posedge clk) disable iff (rst)
    !out_ch.valid |-> (sel == 2'd0))
    else $error("byte select not cleared on empty queue");
`endif

endmodule

// ===== hw/rtl/tcp_header_timestamp_seq_rewrite.sv =====
// ----------------------------------------------------------------------------
// tcp_header_timestamp_seq_rewrite
// streams a tcp header byte by byte, rewriting sequence and timestamp words
// ----------------------------------------------------------------------------
// usage:
//   in_ch carries one header byte per transfer, last_in on the final byte.
//   out_ch returns the header byte for byte; last_out marks the end of a
//   header and status is valid with it (ok, no options, malformed, bad ts len).
//   cfg_we/cfg_idx/cfg_data write offsets and enables; write only when idle.
// timing:
//   one input byte per cycle sustained while the queue has a free row. a
//   plain echoed byte passes through the input register, then the output
//   queue, before it is presented on out_ch. the four bytes of a rewritten
//   word are held until the fourth arrives and then leave as one row, one
//   byte per transfer; the 8-row output queue absorbs that burst so the input
//   side keeps taking a byte every cycle while out_ch.ready stays high.
// reset:
//   rst clears the configuration, the parse state and the queue.
// stalls:
//   when out_ch.ready is low the queue fills; once it is full the input
//   register holds its byte and in_ch.ready drops until a row drains.
// ----------------------------------------------------------------------------
module tcp_header_timestamp_seq_rewrite
  import tcphr_pkg::*;
#(
  parameter int QDepth = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [31:0] cfg_data,
  tcphr_in_if.sink    in_ch,
  tcphr_out_if.source out_ch
);

  cfg_t       cfg;
  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_last;
  logic       take;
  logic       space;
  logic       push;
  row_t       row;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_TS_OFFSET:  cfg.ts_offset  <= cfg_data;
        CFG_TS_ENABLE:  cfg.ts_enable  <= cfg_data[0];
        CFG_SEQ_OFFSET: cfg.seq_offset <= cfg_data;
        CFG_SEQ_ENABLE: cfg.seq_enable <= cfg_data[0];
        default:        cfg <= cfg;
      endcase
    end
  end

  // input register: byte is processed once the queue has a free row
  assign take        = in_vld && space;
  assign in_ch.ready = !in_vld || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld <= in_ch.valid;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte <= in_ch.hdr_byte;
      in_last <= in_ch.last_in;
    end
  end

  // header tracking, option walk and rewrite
  tcphr_parse u_parse (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .take     (take),
    .hdr_byte (in_byte),
    .last_in  (in_last),
    .push     (push),
    .row      (row)
  );

  // output rows, serialized one byte per transfer
  tcphr_outq #(
    .QDepth (QDepth)
  ) u_outq (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .row    (row),
    .space  (space),
    .out_ch (out_ch)
  );

`ifndef SYNTH
  a_take_needs_item: assert property (@(posedge clk) disable iff (rst)
    push |-> take)
    else $error("row pushed without an input byte");

  a_hold_when_blocked: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !space) |=> in_vld)
    else $error("input byte dropped while queue full");

  a_hold_payload: assert property (@(posedge clk) disable iff (rst)
    (in_vld && !take) |=> ($stable(in_byte) && $stable(in_last)))
    else $error("input byte changed while waiting");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the tcp header timestamp/sequence rewriter: a
// queue-fed driver streams whole headers (clean, broken, truncated and noisy
// option areas), a byte-level rewrite model predicts every output transfer,
// and a monitor compares the output stream in order under random backpressure
// ----------------------------------------------------------------------------
module tb_top;
  import tcphr_pkg::*;

  // header shapes the generator can build
  localparam int SH_TS_OK      = 0;
  localparam int SH_NO_OPTS    = 1;
  localparam int SH_END_LIST   = 2;
  localparam int SH_SHORT_OPT  = 3;
  localparam int SH_BAD_TS_LEN = 4;
  localparam int SH_TS_NO_FIT  = 5;
  localparam int SH_EARLY_END  = 6;
  localparam int SH_NOISE      = 7;
  localparam int ShapePick     = 9;    // picks above SH_NOISE fall back to a clean header

  localparam int PhaseBytes = 56;
  localparam int HoldCycles = 200;
  localparam int Settle     = 8;
  localparam int CycleLimit = 200000;

  typedef struct {
    logic [7:0] b;
    logic       last;
  } hdr_item_t;

  typedef struct {
    logic [7:0] b;
    logic       last;
    status_t    st;
  } out_item_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_idx;
  logic [31:0] cfg_data;

  tcphr_in_if  in_ch ();
  tcphr_out_if out_ch ();

  tcp_header_timestamp_seq_rewrite uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_ch    (in_ch),
    .out_ch   (out_ch)
  );

  // pending header bytes and the bytes we expect back
  hdr_item_t tx_bytes[$];
  out_item_t expected_bytes[$];

  int mismatches    = 0;
  int cycle_count   = 0;
  int drv_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_left     = 0;
  bit hold_start    = 1'b0;

  // register copies seen by the rewrite model
  logic [31:0] cur_ts_off  = '0;
  logic        cur_ts_en   = 1'b0;
  logic [31:0] cur_seq_off = '0;
  logic        cur_seq_en  = 1'b0;

  // per-header parse state of the rewrite model
  logic [5:0]  rw_pos  = '0;
  logic [5:0]  rw_hlen = '0;
  phase_t      rw_phase = PH_KIND;
  logic [7:0]  rw_skip = '0;
  logic [31:0] rw_hold = '0;
  logic [1:0]  rw_cnt  = '0;
  status_t     rw_code = ST_OK;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // rewrite model
  // --------------------------------------------------------------------------

  function automatic void close_walk(input status_t code);
    rw_phase = PH_DONE;
    rw_code  = code;
  endfunction

  // one step of the option walk on an echoed (not held) byte
  function automatic void walk_option(input logic [7:0] b, input int rem);
    case (rw_phase)
      PH_KIND: begin
        if (b == OptEnd) begin
          close_walk(ST_OK);
        end else if (b != OptNop) begin
          if (rem < OptMinLen) close_walk(ST_MALFORMED);
          else if (b == OptTs) rw_phase = PH_LEN_TS;
          else rw_phase = PH_LEN_OTHER;
        end
      end
      PH_LEN_OTHER: begin
        if (b < OptMinLen || b > rem + 1) begin
          close_walk(ST_MALFORMED);
        end else if (b == OptMinLen) begin
          rw_phase = PH_KIND;
        end else begin
          rw_skip  = b - OptMinLen;
          rw_phase = PH_SKIP;
        end
      end
      PH_LEN_TS: begin
        if (b != OptTsLen) begin
          close_walk(ST_BAD_TS_LEN);
        end else if (rem + 1 < OptTsLen) begin
          close_walk(ST_MALFORMED);
        end else begin
          rw_phase = PH_TSVAL;
          rw_cnt   = '0;
          rw_hold  = '0;
        end
      end
      PH_SKIP: begin
        rw_skip = rw_skip - 8'd1;
        if (rw_skip == 8'd0) rw_phase = PH_KIND;
      end
      default: ;
    endcase
  endfunction

  // predicts the output bytes caused by one accepted header byte
  function automatic void rewrite_byte(input logic [7:0] b, input logic last);
    logic [7:0]  outs[4];
    logic [31:0] w;
    logic        opts;
    logic        walk;
    status_t     st;
    out_item_t   rec;
    int          n;
    int          i;
    n  = 0;
    st = ST_OK;
    if (rw_pos == DoffPos) rw_hlen = {b[7:4], 2'b00};
    opts = rw_hlen > BaseLen;
    walk = opts && rw_pos >= BaseLen && rw_pos < rw_hlen && rw_phase != PH_DONE;

    if (rw_cnt != 2'd0 || (rw_pos == SeqPos && cur_seq_en) ||
        (walk && (rw_phase == PH_TSVAL || rw_phase == PH_TSECR))) begin
      // word being held: emit all four bytes once complete
      rw_hold = {rw_hold[23:0], b};
      if (rw_cnt == 2'd3) begin
        w = rw_hold;
        if (rw_pos < SeqEnd) begin
          if (cur_seq_en) w = w + cur_seq_off;
        end else begin
          if (cur_ts_en) w = w + cur_ts_off;
          if (rw_phase == PH_TSVAL) rw_phase = PH_TSECR;
          else close_walk(ST_OK);
        end
        for (i = 0; i < 4; i++) outs[i] = w[31 - 8 * i -: 8];
        n       = 4;
        rw_cnt  = '0;
        rw_hold = '0;
      end else begin
        rw_cnt = rw_cnt + 2'd1;
      end
    end else begin
      if (walk) walk_option(b, rw_hlen - rw_pos);
      outs[0] = b;
      n = 1;
    end

    // header ends while the walk is still running
    if (opts && rw_pos >= BaseLen && rw_pos + 7'd1 == rw_hlen && rw_phase != PH_DONE) begin
      if (rw_phase == PH_KIND) close_walk(ST_OK);
      else close_walk(ST_MALFORMED);
    end

    if (last) begin
      // a partly held word leaves unmodified ahead of the last mark
      for (i = int'(rw_cnt) - 1; i >= 0; i--) begin
        outs[n] = rw_hold[8 * i +: 8];
        n++;
      end
      if (!cur_ts_en) st = ST_OK;
      else if (!opts) st = ST_NO_OPTS;
      else if (rw_phase == PH_DONE) st = rw_code;
      else st = ST_MALFORMED;
      rw_pos   = '0;
      rw_hlen  = '0;
      rw_phase = PH_KIND;
      rw_skip  = '0;
      rw_hold  = '0;
      rw_cnt   = '0;
      rw_code  = ST_OK;
    end else if (rw_pos < PosMax) begin
      rw_pos = rw_pos + 6'd1;
    end

    for (i = 0; i < n; i++) begin
      rec.b    = outs[i];
      rec.last = last && (i == n - 1);
      rec.st   = rec.last ? st : ST_OK;
      expected_bytes.insert(expected_bytes.size(), rec);
    end
  endfunction

  // --------------------------------------------------------------------------
  // driver: presents queued bytes, predicts each transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    hdr_item_t nxt;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) rewrite_byte(in_ch.hdr_byte, in_ch.last_in);
      // only move on once the current byte is gone
      if (!in_ch.valid || in_ch.ready) begin
        if (tx_bytes.size() != 0 && $urandom_range(99) >= drv_idle_pct) begin
          nxt = tx_bytes.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.hdr_byte <= nxt.b;
          in_ch.last_in  <= nxt.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here
  always @(posedge clk) begin
    if (hold_start) hold_left <= HoldCycles;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // --------------------------------------------------------------------------
  // monitor: random ready, in-order compare of every output transfer
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    out_item_t exp_rec;
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected transfer byte %02h last %b status %0d", $time,
                   out_ch.out_byte, out_ch.last_out, out_ch.status);
          mismatches++;
        end else begin
          exp_rec = expected_bytes.pop_front();
          if (out_ch.out_byte !== exp_rec.b) begin
            $display("%0t: out_byte expected %02h actual %02h", $time, exp_rec.b,
                     out_ch.out_byte);
            mismatches++;
          end
          if (out_ch.last_out !== exp_rec.last) begin
            $display("%0t: last_out expected %b actual %b", $time, exp_rec.last,
                     out_ch.last_out);
            mismatches++;
          end
          if (out_ch.status !== exp_rec.st) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_rec.st,
                     out_ch.status);
            mismatches++;
          end
        end
      end
      out_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // stimulus helpers
  // --------------------------------------------------------------------------

  // writes all four registers back to back, block must be idle
  task automatic load_regs(input logic [31:0] ts_off, input logic ts_en,
                           input logic [31:0] seq_off, input logic seq_en);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TS_OFFSET;
    cfg_data <= ts_off;
    @(posedge clk);
    cfg_idx  <= CFG_TS_ENABLE;
    cfg_data <= {31'd0, ts_en};
    @(posedge clk);
    cfg_idx  <= CFG_SEQ_OFFSET;
    cfg_data <= seq_off;
    @(posedge clk);
    cfg_idx  <= CFG_SEQ_ENABLE;
    cfg_data <= {31'd0, seq_en};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_ts_off  = ts_off;
    cur_ts_en   = ts_en;
    cur_seq_off = seq_off;
    cur_seq_en  = seq_en;
    @(negedge clk);
  endtask

  // waits until every queued byte went in and every expected byte came out
  task automatic wait_drained(input int settle);
    do @(negedge clk);
    while (tx_bytes.size() != 0 || in_ch.valid || expected_bytes.size() != 0);
    repeat (settle) @(negedge clk);
  endtask

  function automatic void push_item(input logic [7:0] b, input logic last);
    hdr_item_t it;
    it.b    = b;
    it.last = last;
    tx_bytes.insert(tx_bytes.size(), it);
  endfunction

  // random nops and skippable options, leaving at least keep bytes of room
  function automatic void add_filler(ref logic [7:0] h[$], ref int room, input int keep);
    int n;
    int k;
    while (room > keep && $urandom_range(3) != 0) begin
      if (room - keep < 2 || $urandom_range(2) == 0) begin
        h.insert(h.size(), OptNop);
        room--;
      end else begin
        n = $urandom_range((room - keep > 7) ? 7 : room - keep, 2);
        k = $urandom_range(255, 2);
        if (k == OptTs) k++;
        h.insert(h.size(), 8'(k));
        h.insert(h.size(), 8'(n));
        repeat (n - 2) h.insert(h.size(), 8'($urandom));
        room -= n;
      end
    end
  endfunction

  // builds one header of the given shape and queues it; with split set the
  // sender pauses halfway until every expected byte is back
  task automatic queue_header(input int shape, input bit split, output int nbytes);
    logic [7:0] h[$];
    int doff;
    int hlen;
    int room;
    int keep;
    int k;
    int i;
    if (shape == SH_NO_OPTS) doff = $urandom_range(5);
    else if (shape == SH_TS_OK || shape == SH_EARLY_END) doff = $urandom_range(15, 8);
    else doff = $urandom_range(15, 6);
    hlen = doff * 4;
    repeat (BaseLen) h.insert(h.size(), 8'($urandom));
    h[DoffPos] = {doff[3:0], h[DoffPos][3:0]};
    room = hlen - BaseLen;

    case (shape)
      SH_TS_OK, SH_EARLY_END: begin
        add_filler(h, room, OptTsLen);
        h.insert(h.size(), OptTs);
        h.insert(h.size(), OptTsLen);
      end
      SH_END_LIST: begin
        add_filler(h, room, 1);
        h.insert(h.size(), OptEnd);
      end
      SH_SHORT_OPT: begin
        // length below the minimum, or one running past the header
        add_filler(h, room, OptMinLen);
        k = $urandom_range(255, 2);
        if (k == OptTs) k++;
        h.insert(h.size(), 8'(k));
        if ($urandom_range(1)) h.insert(h.size(), 8'($urandom_range(1)));
        else h.insert(h.size(), 8'($urandom_range(255, room + 1)));
      end
      SH_BAD_TS_LEN: begin
        add_filler(h, room, OptMinLen);
        k = $urandom_range(255);
        if (k == OptTsLen) k++;
        h.insert(h.size(), OptTs);
        h.insert(h.size(), 8'(k));
      end
      SH_TS_NO_FIT: begin
        // timestamp starts too close to the end of the header
        keep = $urandom_range((room < 9) ? room : 9, 2);
        add_filler(h, room, keep);
        while (room > keep) begin
          h.insert(h.size(), OptNop);
          room--;
        end
        h.insert(h.size(), OptTs);
        h.insert(h.size(), OptTsLen);
      end
      SH_NOISE: begin
        // small values hit the interesting kinds and lengths often
        while (h.size() < hlen) begin
          if ($urandom_range(1)) h.insert(h.size(), 8'($urandom_range(11)));
          else h.insert(h.size(), 8'($urandom));
        end
      end
      default: ;
    endcase

    while (h.size() < hlen) h.insert(h.size(), 8'($urandom));
    // bytes past the header length
    if ($urandom_range(3) == 0) repeat ($urandom_range(6, 1)) h.insert(h.size(), 8'($urandom));
    nbytes = h.size();
    if (shape == SH_EARLY_END) nbytes = $urandom_range(h.size() - 1, 1);

    for (i = 0; i < nbytes; i++) begin
      if (split && i == nbytes / 2) wait_drained(0);
      push_item(h[i], i == nbytes - 1);
    end
  endtask

  // queues random headers until the byte budget is met
  task automatic fill_random(input int budget, input bit with_split);
    int done;
    int got;
    int shape;
    bit split_done;
    done       = 0;
    split_done = 1'b0;
    while (done < budget) begin
      shape = $urandom_range(ShapePick);
      if (shape > SH_NOISE) shape = SH_TS_OK;
      if (with_split && !split_done && done > budget / 3) begin
        queue_header(SH_TS_OK, 1'b1, got);
        split_done = 1'b1;
      end else begin
        queue_header(shape, 1'b0, got);
      end
      done += got;
    end
  endtask

  // --------------------------------------------------------------------------
  // test sequence
  // --------------------------------------------------------------------------
  initial begin
    int i;
    logic [7:0] b;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_TS_OFFSET;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.hdr_byte  = '0;
    in_ch.last_in   = 1'b0;
    out_ch.ready    = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: one-byte headers at both byte extremes, then a short header
    // with a wrapping sequence number, a nop and an end-of-list option
    load_regs(32'h7fff_ffff, 1'b1, 32'h8000_0000, 1'b1);
    push_item(8'hff, 1'b1);
    push_item(8'h00, 1'b1);
    for (i = 0; i < 24; i++) begin
      case (i)
        4, 5, 6, 7: b = 8'hff;
        12:         b = 8'h60;
        20:         b = OptNop;
        21:         b = OptEnd;
        22, 23:     b = 8'hff;
        default:    b = 8'h00;
      endcase
      push_item(b, i == 23);
    end
    wait_drained(Settle);

    // full rate both sides, with one mid-header sender pause
    load_regs($urandom, 1'b1, $urandom, 1'b1);
    drv_idle_pct  = 0;
    rcv_stall_pct = 0;
    fill_random(PhaseBytes, 1'b1);
    wait_drained(Settle);

    // sparse sender, sequence rewrite off
    load_regs(32'hffff_ffff, 1'b1, $urandom, 1'b0);
    drv_idle_pct  = 87;
    rcv_stall_pct = 0;
    fill_random(PhaseBytes, 1'b0);
    wait_drained(Settle);

    // heavy backpressure, timestamp rewrite off
    load_regs($urandom, 1'b0, $urandom, 1'b1);
    drv_idle_pct  = 0;
    rcv_stall_pct = 87;
    fill_random(PhaseBytes, 1'b0);
    wait_drained(Settle);

    // light gaps on both sides, offsets at the signed extremes
    load_regs(32'h8000_0000, 1'b1, 32'h7fff_ffff, 1'b1);
    drv_idle_pct  = 19;
    rcv_stall_pct = 19;
    fill_random(PhaseBytes, 1'b0);
    wait_drained(Settle);

    // zero offsets; receiver holds off long enough to fill the block
    load_regs(32'h0, 1'b1, 32'h0, 1'b1);
    drv_idle_pct  = 0;
    rcv_stall_pct = 0;
    fill_random(PhaseBytes, 1'b0);
    hold_start = 1'b1;
    @(negedge clk);
    hold_start = 1'b0;
    wait_drained(20);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/tcphr_pkg.sv
hw/rtl/tcphr_if.sv
hw/rtl/tcphr_parse.sv
hw/rtl/tcphr_outq.sv
hw/rtl/tcp_header_timestamp_seq_rewrite.sv
dv/tb_top.sv
